@@ hdl/slot_pool_with_compaction_assert.svh @@
// Assertion macros shared by the slot pool checker.
`ifndef SLOT_POOL_WITH_COMPACTION_ASSERT_SVH
`define SLOT_POOL_WITH_COMPACTION_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot pool check failed");

// Consequent checked at the clock edge after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot pool check failed");

`endif

@@ hdl/spc_pkg.sv @@
// Shared types and constants of the slot pool with compaction.
package spc_pkg;

    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 6;
    localparam int CFG_W    = 5;
    localparam int CMP_W    = 7;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 5'd16;
    localparam logic             REG_POOL_SIZE   = 1'b0;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_GET     = 2'd2,
        REQ_COMPACT = 2'd3
    } t_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic cinit;
        logic step;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
        logic cnt_zero;
    } t_status;

endpackage

@@ hdl/spc_ctrl.sv @@
// Controller state machine of the slot pool: request dispatch and compaction walk.
module spc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  spc_pkg::t_req    i_req_type,
    input  spc_pkg::t_status i_status,
    output spc_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import spc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        o_cmd.exec  = accept && (i_req_type != REQ_COMPACT);
        o_cmd.cinit = accept && (i_req_type == REQ_COMPACT);
        o_cmd.step  = (r_state == S_WALK);
        o_cmd.fin   = (r_state == S_FIN);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.cinit) begin
                    n_state = i_status.cnt_zero ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

@@ hdl/spc_dp.sv @@
// Datapath of the slot pool: handle memory, occupancy flags, count and result registers.
module spc_dp #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spc_pkg::t_cmd                 i_cmd,
    output spc_pkg::t_status              o_status,
    input  logic [spc_pkg::CFG_W-1:0]     i_pool_size,
    input  spc_pkg::t_req                 i_req_type,
    input  logic [spc_pkg::HANDLE_W-1:0]  i_handle_in,
    input  logic [spc_pkg::SLOT_W-1:0]    i_slot_in,
    output logic                          o_result_valid,
    output logic                          o_result_kind,
    output logic                          o_ok,
    output logic [spc_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [spc_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_last
);
    import spc_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SLOTS);

    logic [HANDLE_W-1:0] r_mem [MAX_SLOTS];
    logic [HANDLE_W-1:0] r_rd_data;
    logic [MAX_SLOTS-1:0] r_occ, n_occ;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_holes;
    logic                r_mv_vld;
    logic [IDX_W-1:0]    r_mv_dst;
    logic                r_rd_occ;
    logic                r_cmp_vld;
    logic                r_cmp_ok;
    logic [SLOT_W-1:0]   r_cmp_slot;
    logic                r_cmp_get;

    logic [CMP_W-1:0] pool_c, eff_c, cnt_c, slot_c;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             app_ok;
    logic             do_append, do_clear;
    logic             mv_now;
    logic [IDX_W-1:0] mv_dst;
    logic [IDX_W-1:0] rd_addr;

    assign pool_c   = CMP_W'(i_pool_size);
    assign eff_c    = (pool_c < MAX_C) ? pool_c : MAX_C;
    assign cnt_c    = CMP_W'(r_count);
    assign slot_c   = CMP_W'(i_slot_in);
    assign slot_ok  = (slot_c < eff_c);
    assign slot_idx = i_slot_in[IDX_W-1:0];

    // Lowest empty slot below the effective pool size.
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i] && (CMP_W'(i) < eff_c)) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign app_ok    = (i_handle_in != '0) && (cnt_c < eff_c) && free_hit;
    assign do_append = i_cmd.exec && (i_req_type == REQ_APPEND) && app_ok;
    assign do_clear  = i_cmd.exec && (i_req_type == REQ_CLEAR) && slot_ok;

    // An occupied slot met after a hole slides down by the hole count.
    assign mv_now  = i_cmd.step && r_occ[r_idx] && (r_holes != '0);
    assign mv_dst  = r_idx - r_holes[IDX_W-1:0];
    assign rd_addr = i_cmd.step ? r_idx : slot_idx;

    assign o_status.walk_last = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign o_status.cnt_zero  = (r_count == '0);

    always_comb begin
        n_occ = r_occ;
        if (do_append) begin
            n_occ[free_idx] = 1'b1;
        end
        if (do_clear) begin
            n_occ[slot_idx] = 1'b0;
        end
        if (mv_now) begin
            n_occ[r_idx]  = 1'b0;
            n_occ[mv_dst] = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_append) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.fin) begin
            n_count = r_count - r_holes;
        end
    end

    // Handle memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_mem[free_idx] <= i_handle_in;
        end else if (r_mv_vld) begin
            r_mem[r_mv_dst] <= r_rd_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_count   <= '0;
            r_mv_vld  <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_count   <= n_count;
            r_mv_vld  <= mv_now;
            r_cmp_vld <= i_cmd.exec || i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cinit) begin
            r_idx   <= '0;
            r_holes <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (!r_occ[r_idx]) begin
                r_holes <= r_holes + CNT_W'(1);
            end
        end
        if (mv_now) begin
            r_mv_dst <= mv_dst;
        end
        if (i_cmd.exec) begin
            r_rd_occ   <= r_occ[slot_idx];
            r_cmp_get  <= (i_req_type == REQ_GET) && slot_ok;
            r_cmp_slot <= do_append ? SLOT_W'(free_idx) : '0;
            case (i_req_type)
                REQ_APPEND:           r_cmp_ok <= app_ok;
                REQ_CLEAR, REQ_GET:   r_cmp_ok <= slot_ok;
                default:              r_cmp_ok <= 1'b1;
            endcase
        end else if (i_cmd.fin) begin
            r_cmp_get  <= 1'b0;
            r_cmp_slot <= '0;
            r_cmp_ok   <= 1'b1;
        end
    end

    assign o_result_valid = r_mv_vld || r_cmp_vld;
    assign o_result_kind  = r_mv_vld;
    assign o_ok           = r_mv_vld || r_cmp_ok;
    assign o_slot_out     = r_mv_vld ? SLOT_W'(r_mv_dst) : r_cmp_slot;
    assign o_handle_out   = (r_mv_vld || (r_cmp_get && r_rd_occ)) ? r_rd_data : '0;
    assign o_last         = !r_mv_vld && r_cmp_vld;

endmodule

@@ hdl/slot_pool_with_compaction.sv @@
// Top level of the slot pool with compaction: configuration register, controller and datapath.
//
// This block keeps a first-fit table of MAX_SLOTS handle slots, where an
// occupancy flag marks each used slot and a zero handle is refused, plus an
// entry count. An item is accepted at a rising edge where start is high and
// busy is low. Append, clear and get leave busy low, so such items may be
// issued every cycle, and each one's single completion result appears in the
// cycle after acceptance. Compaction holds busy high through its walk and its
// final step; the handle memory has a single read port, so the walk visits
// one slot per cycle. Each move report appears in the cycle after its slot is
// visited, and the final completion result, marked by o_last, is registered
// from the final step. Every result is shown for exactly one cycle on
// o_result_valid and the receiver cannot stall it. The pool_size register
// sits at byte address 0 of the APB port and must only be written while no
// item is in flight.
module slot_pool_with_compaction #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [spc_pkg::HANDLE_W-1:0]  i_handle_in,
    input  logic [spc_pkg::SLOT_W-1:0]    i_slot_in,
    output logic                          o_result_valid,
    output logic                          o_result_kind,
    output logic                          o_ok,
    output logic [spc_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [spc_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spc_pkg::ADDR_W-1:0]    paddr,
    input  logic [spc_pkg::DATA_W-1:0]    pwdata,
    output logic [spc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import spc_pkg::*;

    logic [CFG_W-1:0] r_pool_size;
    logic             reg_sel;
    logic             cfg_wr;
    t_req             req;
    t_cmd             cmd;
    t_status          status;

    // Register index is the word address; only pool_size exists.
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_POOL_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? DATA_W'(r_pool_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_SIZE_RESET;
        end else if (cfg_wr && reg_sel) begin
            r_pool_size <= pwdata[CFG_W-1:0];
        end
    end

    assign req = t_req'(i_req_type);

    spc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (req),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    spc_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_pool_size    (r_pool_size),
        .i_req_type     (req),
        .i_handle_in    (i_handle_in),
        .i_slot_in      (i_slot_in),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_ok           (o_ok),
        .o_slot_out     (o_slot_out),
        .o_handle_out   (o_handle_out),
        .o_last         (o_last)
    );

endmodule

@@ hdl/spc_chk.sv @@
// Port-level assertion checker for the slot pool, with its bind to the top level.
`include "slot_pool_with_compaction_assert.svh"

module spc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    i_req_type,
    input logic                          o_result_valid,
    input logic                          o_result_kind,
    input logic                          o_ok,
    input logic [spc_pkg::SLOT_W-1:0]    o_slot_out,
    input logic [spc_pkg::HANDLE_W-1:0]  o_handle_out,
    input logic                          o_last
);
    import spc_pkg::*;

    `SPC_ASSERT_IMPL(a_move_shape, o_result_valid && o_result_kind, o_ok && !o_last)
    `SPC_ASSERT_IMPL(a_fail_clean, o_result_valid && !o_ok, (o_slot_out == '0) && (o_handle_out == '0))
    `SPC_ASSERT_NEXT(a_simple_done, start && !busy && (i_req_type != REQ_COMPACT), o_result_valid && o_last)
    `SPC_ASSERT_NEXT(a_compact_busy, start && !busy && (i_req_type == REQ_COMPACT), busy && !o_result_valid)

endmodule

bind slot_pool_with_compaction spc_chk u_chk (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the slot pool with compaction.
module testbench;
    import spc_pkg::*;

    localparam int SLOT_COUNT    = 16;
    localparam int SETTLE_CYCLES = SLOT_COUNT + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 56;
    localparam int PHASES        = 8;
    localparam int DIRECTED_ROWS = 24;

    // The pool_size register is register 0, so it sits at byte address 0.
    localparam logic [ADDR_W-1:0] POOL_SIZE_ADDR = {REG_POOL_SIZE, 2'b00};

    // One result as it appears on the result ports.
    typedef struct packed {
        logic                kind;
        logic                ok;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } t_pool_reply;

    // A row of the directed table. Where typed is set, reply holds the
    // expected completion written out by hand; otherwise the shadow pool
    // decides what to expect.
    typedef struct packed {
        t_req                req;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        logic                typed;
        t_pool_reply         reply;
    } t_directed_row;

    localparam t_pool_reply REPLY_FAIL = '{1'b0, 1'b0, 6'd0, 32'h0, 1'b1};
    localparam t_pool_reply REPLY_DONE = '{1'b0, 1'b1, 6'd0, 32'h0, 1'b1};
    localparam t_pool_reply REPLY_NONE = '{1'b0, 1'b0, 6'd0, 32'h0, 1'b0};

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_req_type;
    logic [HANDLE_W-1:0] i_handle_in;
    logic [SLOT_W-1:0]   i_slot_in;
    logic                o_result_valid;
    logic                o_result_kind;
    logic                o_ok;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [HANDLE_W-1:0] o_handle_out;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the pool: slot contents, entry count and pool_size.
    logic [HANDLE_W-1:0] shadow_slots [SLOT_COUNT];
    logic [CFG_W-1:0]    shadow_count;
    logic [CFG_W-1:0]    shadow_pool_size;

    // Results that the accepted items still owe, oldest first.
    t_pool_reply replies_due [$];

    t_directed_row directed_rows [DIRECTED_ROWS];

    int error_count;
    int cycle_count;
    int replies_seen;
    int moves_seen;
    int appends_sent;
    int clears_sent;
    int gets_sent;
    int compacts_sent;
    int appends_placed;
    int appends_refused;

    slot_pool_with_compaction #(
        .MAX_SLOTS(SLOT_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_handle_in   (i_handle_in),
        .i_slot_in     (i_slot_in),
        .o_result_valid(o_result_valid),
        .o_result_kind (o_result_kind),
        .o_ok          (o_ok),
        .o_slot_out    (o_slot_out),
        .o_handle_out  (o_handle_out),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out what one accepted item does to the pool and queues every
    // result that it owes. The effective size is pool_size capped at the
    // number of physical slots.
    task automatic apply_pool_request(input t_req req, input logic [HANDLE_W-1:0] handle,
                                      input logic [SLOT_W-1:0] slot);
        int          eff;
        int          holes;
        int          idx;
        bit          placed;
        t_pool_reply reply;
        t_pool_reply move;

        eff   = (shadow_pool_size < SLOT_COUNT) ? int'(shadow_pool_size) : SLOT_COUNT;
        reply = REPLY_FAIL;
        case (req)
            REQ_APPEND: begin
                // A null handle or a full count is refused before any search.
                if (handle != '0 && shadow_count < eff) begin
                    placed = 1'b0;
                    for (idx = 0; idx < eff && !placed; idx++) begin
                        if (shadow_slots[idx] == '0) begin
                            shadow_slots[idx] = handle;
                            shadow_count      = shadow_count + 1'b1;
                            reply.ok          = 1'b1;
                            reply.slot        = SLOT_W'(idx);
                            placed            = 1'b1;
                        end
                    end
                end
                if (reply.ok) appends_placed++;
                else appends_refused++;
            end
            REQ_CLEAR: begin
                // Clearing leaves the entry count alone, even on an empty slot.
                if (slot < eff) begin
                    shadow_slots[slot] = '0;
                    reply.ok           = 1'b1;
                end
            end
            REQ_GET: begin
                if (slot < eff) begin
                    reply.ok     = 1'b1;
                    reply.handle = shadow_slots[slot];
                end
            end
            default: begin
                // Compaction walks only the slots below the entry count and
                // slides each entry down by the holes passed so far.
                holes = 0;
                for (idx = 0; idx < int'(shadow_count) && idx < SLOT_COUNT; idx++) begin
                    if (shadow_slots[idx] == '0) begin
                        holes++;
                    end else if (holes != 0) begin
                        shadow_slots[idx - holes] = shadow_slots[idx];
                        shadow_slots[idx]         = '0;
                        move        = REPLY_NONE;
                        move.kind   = 1'b1;
                        move.ok     = 1'b1;
                        move.slot   = SLOT_W'(idx - holes);
                        move.handle = shadow_slots[idx - holes];
                        replies_due.push_back(move);
                    end
                end
                shadow_count = shadow_count - CFG_W'(holes);
                reply.ok     = 1'b1;
            end
        endcase
        replies_due.push_back(reply);
    endtask

    // Presents one item from the falling edge on and holds it until the
    // block takes it. Busy is sampled at the rising edge, before the block
    // updates it.
    task automatic issue_item(input t_req req, input logic [HANDLE_W-1:0] handle,
                              input logic [SLOT_W-1:0] slot);
        @(negedge i_clk);
        start       = 1'b1;
        i_req_type  = req;
        i_handle_in = handle;
        i_slot_in   = slot;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_pool_request(req, handle, slot);
        case (req)
            REQ_APPEND: appends_sent++;
            REQ_CLEAR:  clears_sent++;
            REQ_GET:    gets_sent++;
            default:    compacts_sent++;
        endcase
    endtask

    // Idle cycles on the item port carry random junk on the fields.
    task automatic idle_cycles(input int count);
        repeat (count) begin
            @(negedge i_clk);
            start       = 1'b0;
            i_req_type  = 2'($urandom);
            i_handle_in = $urandom;
            i_slot_in   = 6'($urandom);
        end
    endtask

    // Lowers start and waits until every owed result has come back, then
    // lets the compaction walk and its pipeline run out.
    task automatic drain_replies();
        idle_cycles(1);
        while (replies_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reads pool_size back and checks it against the shadow copy.
    task automatic check_pool_size();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        paddr   = POOL_SIZE_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== shadow_pool_size) begin
            $display("%0t: pool_size readback mismatch: expected %0d, got %0d",
                     $realtime, shadow_pool_size, prdata[CFG_W-1:0]);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes pool_size with a setup phase and an access phase, then reads it back.
    task automatic set_pool_size(input logic [CFG_W-1:0] size);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = POOL_SIZE_ADDR;
        pwdata  = DATA_W'(size);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        shadow_pool_size = size;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_pool_size();
    endtask

    // Every result is compared with the oldest one still owed.
    always @(posedge i_clk) begin
        t_pool_reply want;
        t_pool_reply got;

        if (i_rst_n === 1'b1 && o_result_valid !== 1'b0) begin
            got = '{o_result_kind, o_ok, o_slot_out, o_handle_out, o_last};
            if (replies_due.size() == 0) begin
                $display({"%0t: result with nothing owed: ",
                          "kind=%0d ok=%0d slot=%0d handle=%h last=%0d"},
                         $realtime, got.kind, got.ok, got.slot, got.handle, got.last);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                replies_seen++;
                if (want.kind) moves_seen++;
                if (got !== want || o_result_valid !== 1'b1) begin
                    $display({"%0t: result mismatch: expected ",
                              "kind=%0d ok=%0d slot=%0d handle=%h last=%0d"},
                             $realtime, want.kind, want.ok, want.slot, want.handle,
                             want.last);
                    $display({"%0t:                  actual ",
                              "kind=%0d ok=%0d slot=%0d handle=%h last=%0d"},
                             $realtime, got.kind, got.ok, got.slot, got.handle,
                             got.last);
                    error_count++;
                end
            end
        end
    end

    // A run that never drains ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles with %0d results owed",
                     $realtime, cycle_count, replies_due.size());
            $display("slot_pool_with_compaction regression: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0]    pool_plan [PHASES];
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        t_req                req;
        int                  eff;
        int                  pick;
        int                  burst_left;
        int                  phase;
        int                  row;
        int                  item;

        start            = 1'b0;
        i_rst_n          = 1'b0;
        i_req_type       = REQ_APPEND;
        i_handle_in      = '0;
        i_slot_in        = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        error_count      = 0;
        cycle_count      = 0;
        replies_seen     = 0;
        moves_seen       = 0;
        appends_sent     = 0;
        clears_sent      = 0;
        gets_sent        = 0;
        compacts_sent    = 0;
        appends_placed   = 0;
        appends_refused  = 0;
        shadow_count     = '0;
        shadow_pool_size = POOL_SIZE_RESET;
        burst_left       = 0;
        foreach (shadow_slots[i]) shadow_slots[i] = '0;

        // Directed items, all with the reset pool size of 16. The first
        // rows hit the range limits on an empty pool, then a few entries are
        // stored, holes are punched and compaction closes them.
        directed_rows = '{
            '{REQ_GET,     32'h0,         6'd0,  1'b1, REPLY_DONE},
            '{REQ_GET,     32'h0,         6'd63, 1'b1, REPLY_FAIL},
            '{REQ_GET,     32'h0,         6'd16, 1'b1, REPLY_FAIL},
            '{REQ_CLEAR,   32'h0,         6'd16, 1'b1, REPLY_FAIL},
            '{REQ_CLEAR,   32'h0,         6'd63, 1'b1, REPLY_FAIL},
            '{REQ_APPEND,  32'h0,         6'd0,  1'b1, REPLY_FAIL},
            '{REQ_COMPACT, 32'h0,         6'd0,  1'b1, REPLY_DONE},
            '{REQ_APPEND,  32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 1'b1, 6'd0, 32'h0, 1'b1}},
            '{REQ_APPEND,  32'h0000_0001, 6'd63, 1'b1, '{1'b0, 1'b1, 6'd1, 32'h0, 1'b1}},
            '{REQ_APPEND,  32'h8000_0000, 6'd0,  1'b1, '{1'b0, 1'b1, 6'd2, 32'h0, 1'b1}},
            '{REQ_APPEND,  32'hA5A5_A5A5, 6'd0,  1'b1, '{1'b0, 1'b1, 6'd3, 32'h0, 1'b1}},
            '{REQ_APPEND,  32'h5A5A_5A5A, 6'd0,  1'b1, '{1'b0, 1'b1, 6'd4, 32'h0, 1'b1}},
            '{REQ_GET,     32'h0,         6'd0,  1'b1,
              '{1'b0, 1'b1, 6'd0, 32'hFFFF_FFFF, 1'b1}},
            '{REQ_CLEAR,   32'hFFFF_FFFF, 6'd1,  1'b1, REPLY_DONE},
            '{REQ_CLEAR,   32'h0,         6'd1,  1'b1, REPLY_DONE},
            '{REQ_GET,     32'h0,         6'd1,  1'b1, REPLY_DONE},
            '{REQ_GET,     32'h0,         6'd15, 1'b1, REPLY_DONE},
            '{REQ_CLEAR,   32'h0,         6'd3,  1'b1, REPLY_DONE},
            '{REQ_COMPACT, 32'hFFFF_FFFF, 6'd63, 1'b0, REPLY_NONE},
            '{REQ_GET,     32'h0,         6'd0,  1'b0, REPLY_NONE},
            '{REQ_APPEND,  32'h1234_5678, 6'd0,  1'b0, REPLY_NONE},
            '{REQ_CLEAR,   32'h0,         6'd0,  1'b0, REPLY_NONE},
            '{REQ_COMPACT, 32'h0,         6'd0,  1'b0, REPLY_NONE},
            '{REQ_GET,     32'h0,         6'd2,  1'b0, REPLY_NONE}
        };

        // The shrinking and growing pool sizes include both extremes of the
        // field, a zero size and a size above the number of physical slots.
        pool_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'($urandom_range(2, 15)),
                      5'd16, 5'd3, 5'd16};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The register must come out of reset at its default.
        check_pool_size();

        // Directed rows go back to back so that items that leave busy low overlap.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            issue_item(directed_rows[row].req, directed_rows[row].handle,
                       directed_rows[row].slot);
            if (directed_rows[row].typed) replies_due[replies_due.size() - 1] =
                directed_rows[row].reply;
        end
        drain_replies();

        for (phase = 0; phase < PHASES; phase++) begin
            set_pool_size(pool_plan[phase]);
            eff = (shadow_pool_size < SLOT_COUNT) ? int'(shadow_pool_size) : SLOT_COUNT;
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // The sender works in bursts; a gap of zero joins two bursts.
                if (burst_left == 0) begin
                    idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;

                pick = $urandom_range(0, 99);
                if (pick < 45) req = REQ_APPEND;
                else if (pick < 65) req = REQ_CLEAR;
                else if (pick < 85) req = REQ_GET;
                else req = REQ_COMPACT;

                pick = $urandom_range(0, 19);
                if (pick == 0) handle = '0;
                else if (pick == 1) handle = '1;
                else handle = $urandom;

                // Most slot indexes fall inside the pool; some reach anywhere.
                if (eff == 0 || $urandom_range(0, 4) == 0) slot = 6'($urandom);
                else slot = 6'($urandom_range(0, eff - 1));

                issue_item(req, handle, slot);

                // Now and then the sender waits for the block to go quiet.
                if ($urandom_range(0, 39) == 0) drain_replies();
            end
            drain_replies();
        end

        $display({"Covered %0d items: %0d appends (%0d placed, %0d refused), ",
                  "%0d clears, %0d gets, %0d compactions."},
                 appends_sent + clears_sent + gets_sent + compacts_sent, appends_sent,
                 appends_placed, appends_refused, clears_sent, gets_sent, compacts_sent);
        $display("Checked %0d results, %0d of them move reports, over %0d pool size phases.",
                 replies_seen, moves_seen, PHASES + 1);
        if (error_count == 0) begin
            $display("slot_pool_with_compaction regression: pass");
        end else begin
            $display("slot_pool_with_compaction regression: fail");
        end
        $finish;
    end
endmodule

@@ slot_pool_with_compaction.f @@
+incdir+hdl
hdl/spc_pkg.sv
hdl/spc_ctrl.sv
hdl/spc_dp.sv
hdl/slot_pool_with_compaction.sv
hdl/spc_chk.sv
verif/testbench.sv
